// File: rtl/co2_sensor_ppm_estimator_core_defines.svh
// ----------------------------------------------------------------------------
// CO2 ppm estimator assertion macros
// Shared concurrent assertion forms for the estimator checker.
// ----------------------------------------------------------------------------
`ifndef CO2_SENSOR_PPM_ESTIMATOR_CORE_DEFINES_SVH
`define CO2_SENSOR_PPM_ESTIMATOR_CORE_DEFINES_SVH

// property checked outside reset
`define CO2_ASSERT(lbl, clk_s, rst_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) \
    else $error("co2 estimator check failed");

// property checked on every edge, reset included
`define CO2_ASSERT_ALWAYS(lbl, clk_s, prop) \
  lbl: assert property (@(posedge clk_s) prop) \
    else $error("co2 estimator check failed");

`endif

// File: rtl/co2ppm_pkg.sv
// ----------------------------------------------------------------------------
// CO2 ppm estimator package
// Sequencer states, fixed-point constants and the exp2 coefficient table.
// ----------------------------------------------------------------------------
package co2ppm_pkg;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DEN_MUL,
    ST_NUM_MUL,
    ST_MEAN_DIV_GO,
    ST_MEAN_DIV,
    ST_FILT_MUL0,
    ST_FILT_MUL1,
    ST_FILT_SUM,
    ST_EXP_MUL,
    ST_EXP_CLIP,
    ST_LOG_MUL,
    ST_LOG_SPLIT,
    ST_POW_MUL,
    ST_POW_RND,
    ST_PPM,
    ST_OUT
  } seq_state_t;

  // configuration register indexes
  localparam logic [1:0] REG_BATCH_SIZE     = 2'd0;
  localparam logic [1:0] REG_SMOOTH_WEIGHT  = 2'd1;
  localparam logic [1:0] REG_REFERENCE_MV   = 2'd2;
  localparam logic [1:0] REG_ADC_FULL_SCALE = 2'd3;

  // divider geometry
  localparam int DIV_NW = 42;
  localparam int DIV_DW = 24;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // widths and fixed values
  localparam int SUM_W = 20;
  localparam logic [19:0] SUM_MAX      = 20'hFFFFF;
  localparam logic [19:0] PPM_MAX      = 20'hFFFFF;
  localparam logic [19:0] CAL_PPM      = 20'd400;
  localparam logic [23:0] OFFSET_RESET = 24'd384000;   // 1500 mV, Q16.8
  localparam logic [24:0] SPAN_Q8      = 25'd153600;   // 600 mV, Q16.8
  localparam logic [23:0] Q24_MAX      = 24'hFFFFFF;
  localparam logic [31:0] LOG2_400_Q16 = 32'd566484;
  // floor(n / 150) as (n * RECIP_150) >> RECIP_SHIFT, exact for n below 2^28
  localparam logic [31:0] RECIP_150    = 32'd458129845;
  localparam int          RECIP_SHIFT  = 36;
  // 75 rounding plus 150 * 2^19 keeps the dividend positive
  localparam logic [28:0] EXP_NUM_BIAS = 29'd75 + 29'd78643200;
  localparam logic [20:0] E_LOW        = 21'd491520;   // 2^19 - 32768
  localparam logic [20:0] E_HIGH       = 21'd557055;   // 2^19 + 32767
  // e*K + 2^40 + 2048 written as e_off*K + bias, e_off = e + 32768
  localparam logic [40:0] LOG_BIAS =
      41'((64'd1 << 40) - 64'd32768 * 64'd566484 + 64'd2048);
  localparam logic [31:0] ONE_Q30      = 32'h4000_0000;
  localparam logic [63:0] HALF_Q30     = 64'h2000_0000;

  // 2^(2^-(i+1)) in Q2.30
  function automatic logic [31:0] exp2_coef(input logic [3:0] idx);
    logic [31:0] c;
    unique case (idx)
      4'd0:  c = 32'd1518500250;
      4'd1:  c = 32'd1276901417;
      4'd2:  c = 32'd1170923762;
      4'd3:  c = 32'd1121280436;
      4'd4:  c = 32'd1097253708;
      4'd5:  c = 32'd1085434106;
      4'd6:  c = 32'd1079572136;
      4'd7:  c = 32'd1076653033;
      4'd8:  c = 32'd1075196443;
      4'd9:  c = 32'd1074468888;
      4'd10: c = 32'd1074105295;
      4'd11: c = 32'd1073923544;
      4'd12: c = 32'd1073832680;
      4'd13: c = 32'd1073787251;
      4'd14: c = 32'd1073764537;
      4'd15: c = 32'd1073753181;
    endcase
    return c;
  endfunction

endpackage

// File: rtl/co2ppm_div.sv
// ----------------------------------------------------------------------------
// CO2 ppm estimator divider
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module co2ppm_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [co2ppm_pkg::DIV_NW-1:0]   dividend,
  input  logic [co2ppm_pkg::DIV_DW-1:0]   divisor,
  output logic [co2ppm_pkg::DIV_NW-1:0]   quotient,
  output co2ppm_pkg::div_stat_t           stat
);
  import co2ppm_pkg::*;

  localparam int CW = $clog2(DIV_NW + 1);

  logic [DIV_DW-1:0] rem;
  logic [DIV_NW-1:0] quo;
  logic [DIV_DW-1:0] dsr;
  logic [CW-1:0]     cnt;
  logic              busy;
  logic              done;
  logic [DIV_DW:0]   shifted;
  logic [DIV_DW:0]   trial;
  logic              neg;

  // one trial subtraction
  always_comb begin
    shifted = {rem, quo[DIV_NW-1]};
    trial   = shifted - {1'b0, dsr};
    neg     = trial[DIV_DW];
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DIV_NW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      rem <= neg ? shifted[DIV_DW-1:0] : trial[DIV_DW-1:0];
      quo <= {quo[DIV_NW-2:0], ~neg};
    end
  end

  assign quotient  = quo;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// File: rtl/co2_sensor_ppm_estimator_core.sv
// ----------------------------------------------------------------------------
// CO2 sensor ppm estimator core
// Batch averaging, exponential smoothing and log-law ppm conversion.
// ----------------------------------------------------------------------------
// Each sample request that does not close a batch is taken at once, and the
// next may follow straight after it. The sample that closes a batch starts
// the end-of-batch sequence, shorter for a calibrate than for a measure,
// during which s_tready is low. For a measure, one 42-step pass of the
// radix-2 divider for the mean voltage, the exponent divide by 150 as a
// reciprocal multiply and sixteen multiply-and-round steps of the shared
// 32x32 multiplier for 2^frac account for nearly all of it. The last state,
// ST_OUT, waits further while an earlier result is still held. The result
// sits in an output register, so a new batch may start while it waits.
module co2_sensor_ppm_estimator_core #(
  parameter int ADC_BITS = 12
) (
  input  logic                                clk,
  input  logic                                rst,
  // s_tdata: adc_sample
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [((ADC_BITS + 7) / 8) * 8-1:0] s_tdata,
  // s_tuser: cmd
  input  logic [0:0]                          s_tuser,
  // m_tdata: co2_ppm [19:0], voltage_mv [35:20], zero fill
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [39:0]                         m_tdata,
  // m_tuser: saturated
  output logic [0:0]                          m_tuser,
  input  logic                                cfg_we,
  input  logic [1:0]                          cfg_index,
  input  logic [15:0]                         cfg_data
);
  import co2ppm_pkg::*;

  // configuration
  logic [7:0]  batch_size;
  logic [15:0] smoothing_weight;
  logic [12:0] reference_mv;
  logic [15:0] adc_full_scale;

  // state
  seq_state_t  state, state_next;
  logic [SUM_W-1:0] sample_sum;
  logic [7:0]  sample_counter;
  logic [23:0] filtered_mv;
  logic [23:0] zero_offset_mv;
  logic        cmd_r;

  // working registers
  logic [23:0] den;
  logic [23:0] mean;
  logic [40:0] acc;
  logic [15:0] e_off;
  logic [15:0] frac;
  logic signed [13:0] ip;
  logic [31:0] y;
  logic [3:0]  idx;
  logic [19:0] res_ppm;
  logic        res_sat;
  logic [63:0] prod;

  // output register
  logic [19:0] out_ppm;
  logic [15:0] out_mv;
  logic        out_sat;

  // divider
  logic              div_start;
  logic [DIV_NW-1:0] div_dividend;
  logic [DIV_DW-1:0] div_divisor;
  logic [DIV_NW-1:0] div_q;
  div_stat_t         div_stat;

  // multiplier operands
  logic [31:0] mul_a;
  logic [31:0] mul_b;

  // sample accumulation
  logic [ADC_BITS-1:0] sample;
  logic [SUM_W:0]      sum_add;
  logic [SUM_W-1:0]    sum_sat;
  logic [7:0]          cnt_inc;
  logic [7:0]          batch_eff;
  logic [15:0]         fs_eff;
  logic                accept;
  logic                batch_end;
  logic                out_free;

  // end-of-batch arithmetic
  logic [40:0] filt_sum;
  logic [23:0] filt_new;
  logic [24:0] off_sum;
  logic [28:0] exp_num;
  logic [20:0] exp_q;
  logic        exp_ovf;
  logic [40:0] log_u;
  logic [63:0] pow_rnd;
  logic [5:0]  sh;
  logic [40:0] ppm_rnd;
  logic [40:0] ppm_p;

  co2ppm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_q),
    .stat     (div_stat)
  );

  // sample path
  always_comb begin
    sample    = s_tdata[ADC_BITS-1:0];
    sum_add   = {1'b0, sample_sum} + (SUM_W + 1)'(sample);
    sum_sat   = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
    cnt_inc   = sample_counter + 8'd1;
    batch_eff = (batch_size == 8'd0) ? 8'd1 : batch_size;
    fs_eff    = (adc_full_scale == 16'd0) ? 16'd1 : adc_full_scale;
    accept    = s_tvalid && s_tready;
    batch_end = accept && !(cnt_inc < batch_eff);
    out_free  = !m_tvalid || m_tready;
  end

  // end-of-batch arithmetic
  always_comb begin
    filt_sum = acc + prod[40:0] + 41'd32768;
    filt_new = filt_sum[39:16];
    off_sum  = {1'b0, filtered_mv} + SPAN_Q8;
    exp_num  = 29'({zero_offset_mv, 2'b00}) + EXP_NUM_BIAS
             - 29'({filtered_mv, 2'b00});
    exp_q    = prod[RECIP_SHIFT+20:RECIP_SHIFT];
    exp_ovf  = |prod[63:RECIP_SHIFT+21];
    log_u    = prod[40:0] + LOG_BIAS;
    pow_rnd  = prod + HALF_Q30;
    sh       = 6'(14'sd30 - ip);
    ppm_rnd  = 41'(y) + (41'd1 << (sh - 6'd1));
    ppm_p    = ppm_rnd >> sh;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:        if (batch_end) state_next = ST_DEN_MUL;
      ST_DEN_MUL:     state_next = ST_NUM_MUL;
      ST_NUM_MUL:     state_next = ST_MEAN_DIV_GO;
      ST_MEAN_DIV_GO: state_next = ST_MEAN_DIV;
      ST_MEAN_DIV:    if (div_stat.done) state_next = ST_FILT_MUL0;
      ST_FILT_MUL0:   state_next = ST_FILT_MUL1;
      ST_FILT_MUL1:   state_next = ST_FILT_SUM;
      ST_FILT_SUM:    state_next = cmd_r ? ST_OUT : ST_EXP_MUL;
      ST_EXP_MUL:     state_next = ST_EXP_CLIP;
      ST_EXP_CLIP:    state_next = ST_LOG_MUL;
      ST_LOG_MUL:     state_next = ST_LOG_SPLIT;
      ST_LOG_SPLIT:   state_next = ST_POW_MUL;
      ST_POW_MUL:     state_next = ST_POW_RND;
      ST_POW_RND:     state_next = (idx == 4'd15) ? ST_PPM : ST_POW_MUL;
      ST_PPM:         state_next = ST_OUT;
      ST_OUT:         if (out_free) state_next = ST_IDLE;
      default:        state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs: handshake, divider request, multiplier operands
  always_comb begin
    s_tready     = (state == ST_IDLE);
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    mul_a        = '0;
    mul_b        = '0;
    unique case (state)
      ST_DEN_MUL: begin
        mul_a = 32'(fs_eff);
        mul_b = 32'(batch_eff);
      end
      ST_NUM_MUL: begin
        mul_a = 32'(sample_sum);
        mul_b = 32'(reference_mv);
      end
      ST_MEAN_DIV_GO: begin
        div_start    = 1'b1;
        div_dividend = (DIV_NW'(prod[32:0]) << 8) + DIV_NW'(den[23:1]);
        div_divisor  = den;
      end
      ST_FILT_MUL0: begin
        mul_a = 32'(smoothing_weight);
        mul_b = 32'(filtered_mv);
      end
      ST_FILT_MUL1: begin
        mul_a = 32'(17'h10000 - {1'b0, smoothing_weight});
        mul_b = 32'(mean);
      end
      // exponent divide by 150 through the reciprocal
      ST_EXP_MUL: begin
        mul_a = 32'(exp_num);
        mul_b = RECIP_150;
      end
      ST_LOG_MUL: begin
        mul_a = 32'(e_off);
        mul_b = LOG2_400_Q16;
      end
      ST_POW_MUL: begin
        mul_a = y;
        mul_b = frac[4'd15 - idx] ? exp2_coef(idx) : ONE_Q30;
      end
      default: ;
    endcase
  end

  // shared multiplier, product registered
  always_ff @(posedge clk) begin
    prod <= 64'(mul_a) * 64'(mul_b);
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      batch_size       <= 8'd100;
      smoothing_weight <= 16'd64881;
      reference_mv     <= 13'd3300;
      adc_full_scale   <= 16'd4096;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BATCH_SIZE:     batch_size       <= cfg_data[7:0];
        REG_SMOOTH_WEIGHT:  smoothing_weight <= cfg_data;
        REG_REFERENCE_MV:   reference_mv     <= cfg_data[12:0];
        REG_ADC_FULL_SCALE: adc_full_scale   <= cfg_data;
      endcase
    end
  end

  // control state and persistent filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      sample_sum     <= '0;
      sample_counter <= '0;
      filtered_mv    <= '0;
      zero_offset_mv <= OFFSET_RESET;
      m_tvalid       <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        sample_sum     <= sum_sat;
        sample_counter <= cnt_inc;
      end
      if (state == ST_MEAN_DIV_GO) begin
        sample_sum     <= '0;
        sample_counter <= '0;
      end
      if (state == ST_FILT_SUM) begin
        filtered_mv <= filt_new;
      end
      // calibrate: offset follows the fresh filter value
      if (state == ST_OUT && cmd_r && state_next == ST_IDLE) begin
        zero_offset_mv <= off_sum[24] ? Q24_MAX : off_sum[23:0];
      end
      if (state == ST_OUT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (accept) cmd_r <= s_tuser[0];
    unique case (state)
      ST_NUM_MUL: den <= prod[23:0];
      ST_MEAN_DIV: begin
        if (div_stat.done) begin
          mean <= (|div_q[DIV_NW-1:24]) ? Q24_MAX : div_q[23:0];
        end
      end
      ST_FILT_MUL1: acc <= prod[40:0];
      ST_FILT_SUM: begin
        res_ppm <= CAL_PPM;
        res_sat <= 1'b0;
      end
      // exponent clipped to Q4.12 range, kept offset by 32768
      ST_EXP_CLIP: begin
        priority if (exp_ovf || exp_q >= E_HIGH) e_off <= 16'hFFFF;
        else if (exp_q < E_LOW) e_off <= 16'd0;
        else e_off <= 16'(exp_q - E_LOW);
      end
      ST_LOG_SPLIT: begin
        frac <= log_u[27:12];
        ip   <= $signed({1'b0, log_u[40:28]}) - 14'sd4096;
        y    <= ONE_Q30;
        idx  <= 4'd0;
      end
      ST_POW_RND: begin
        y   <= pow_rnd[61:30];
        idx <= idx + 4'd1;
      end
      // scale by 2^ip with rounding and clip
      ST_PPM: begin
        priority if (ip >= 14'sd20) begin
          res_ppm <= PPM_MAX;
          res_sat <= 1'b1;
        end else if (ip < -14'sd10) begin
          res_ppm <= '0;
          res_sat <= 1'b0;
        end else if (ppm_p > 41'(PPM_MAX)) begin
          res_ppm <= PPM_MAX;
          res_sat <= 1'b1;
        end else begin
          res_ppm <= ppm_p[19:0];
          res_sat <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  // output register load
  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      out_ppm <= res_ppm;
      out_mv  <= filtered_mv[23:8];
      out_sat <= res_sat;
    end
  end

  assign m_tdata = {4'b0000, out_mv, out_ppm};
  assign m_tuser = out_sat;

endmodule

// File: rtl/co2ppm_checker.sv
// ----------------------------------------------------------------------------
// CO2 ppm estimator port checker
// Watches the estimator's ports and flags illegal result behaviour.
// ----------------------------------------------------------------------------
`include "co2_sensor_ppm_estimator_core_defines.svh"

module co2ppm_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic [0:0]  m_tuser
);

  // a stalled result holds its value
  `CO2_ASSERT(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))

  // a clipped result always reads full scale
  `CO2_ASSERT(a_sat_max, clk, rst, m_tvalid && m_tuser[0] |-> m_tdata[19:0] == 20'hFFFFF)

  // padding bits above the voltage stay clear
  `CO2_ASSERT(a_pad_zero, clk, rst, m_tvalid |-> m_tdata[39:36] == 4'h0)

  // a pending sample request always sees a defined ready
  `CO2_ASSERT(a_rdy_known, clk, rst, s_tvalid |-> !$isunknown(s_tready))

  // reset leaves no result pending
  `CO2_ASSERT_ALWAYS(a_rst_empty, clk, rst |=> !m_tvalid)

endmodule

bind co2_sensor_ppm_estimator_core co2ppm_checker u_co2ppm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// CO2 ppm estimator core regression bench
// Streams converter samples through the estimator. A bit-exact predictor of
// batch averaging, smoothing, calibration and log-law ppm conversion works out
// each reading. Every reading that comes out is checked field by field.
// ----------------------------------------------------------------------------
module tb;
  import co2ppm_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 200;

  typedef struct {
    logic [19:0] ppm;
    logic [15:0] mv;
    logic        sat;
  } reading_t;

  // 2^(2^-(i+1)) in Q2.30
  localparam longint unsigned EXP2_Q30 [16] = '{
    1518500250, 1276901417, 1170923762, 1121280436,
    1097253708, 1085434106, 1079572136, 1076653033,
    1075196443, 1074468888, 1074105295, 1073923544,
    1073832680, 1073787251, 1073764537, 1073753181
  };

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;   // adc_sample
  logic [0:0]  s_tuser;   // cmd
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;   // co2_ppm, voltage_mv, zero fill
  logic [0:0]  m_tuser;   // saturated
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  co2_sensor_ppm_estimator_core #(.ADC_BITS(12)) u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // predictor state
  logic [7:0]  batch_reg;
  logic [15:0] weight_reg;
  logic [12:0] vref_reg;
  logic [15:0] fscale_reg;
  logic [19:0] acc_sum;
  logic [7:0]  acc_count;
  logic [23:0] filt_q8;
  logic [23:0] offset_q8;

  reading_t pending_readings[$];
  int mismatches;
  int samples_sent;
  int readings_seen;
  int sats_seen;
  int cals_sent;
  int send_idle_pct;
  int recv_idle_pct;
  int idle_count;

  // ppm = 400^((offset - filtered)/600) in fixed point
  function automatic void ppm_from_offset(output logic [19:0] ppm, output logic sat);
    longint diff, e, u, t16, tb, ip, sh;
    longint unsigned y, p;
    logic [15:0] frac;
    diff = longint'(offset_q8) - longint'(filt_q8);
    e = (diff * 4 + 75 + (longint'(150) << 19)) / 150 - (longint'(1) << 19);
    if (e > 32767) e = 32767;
    if (e < -32768) e = -32768;
    u = e * 566484 + (longint'(1) << 40) + 2048;
    t16 = (u >>> 12) - (longint'(1) << 28);
    tb = t16 + (longint'(128) << 16);
    ip = (tb >>> 16) - 128;
    frac = tb[15:0];
    y = 64'd1 << 30;
    for (int i = 0; i < 16; i++) begin
      if (frac[15 - i]) y = (y * EXP2_Q30[i] + (64'd1 << 29)) >> 30;
    end
    sat = 1'b0;
    if (ip >= 20) begin
      sat = 1'b1;
      ppm = 20'hFFFFF;
      return;
    end
    sh = 30 - ip;
    if (sh > 40) begin
      ppm = '0;
      return;
    end
    p = (y + (64'd1 << (sh - 1))) >> sh;
    if (p > 64'hFFFFF) begin
      sat = 1'b1;
      ppm = 20'hFFFFF;
    end else begin
      ppm = p[19:0];
    end
  endfunction

  // fold one accepted sample into the predictor, queue a reading at batch end
  function automatic void absorb_sample(logic [11:0] sample, logic cmd);
    longint unsigned num, den, mean, w, sum_ext;
    longint unsigned batch, fs;
    reading_t r;
    batch = (batch_reg == 0) ? 1 : batch_reg;
    fs = (fscale_reg == 0) ? 1 : fscale_reg;
    sum_ext = longint'(acc_sum) + sample;
    acc_sum = (sum_ext > 64'hFFFFF) ? 20'hFFFFF : sum_ext[19:0];
    acc_count = acc_count + 8'd1;
    if (acc_count < batch) return;
    num = (longint'(acc_sum) * vref_reg) << 8;
    den = fs * batch;
    mean = (num + den / 2) / den;
    if (mean > 64'hFFFFFF) mean = 64'hFFFFFF;
    w = weight_reg;
    filt_q8 = 24'((w * filt_q8 + (65536 - w) * mean + 32768) >> 16);
    acc_sum = '0;
    acc_count = '0;
    if (cmd) begin
      num = longint'(filt_q8) + 153600;
      offset_q8 = (num > 64'hFFFFFF) ? 24'hFFFFFF : num[23:0];
      r.ppm = 20'd400;
      r.sat = 1'b0;
    end else begin
      ppm_from_offset(r.ppm, r.sat);
    end
    r.mv = filt_q8[23:8];
    pending_readings.push_back(r);
  endfunction

  // send one sample request, predictor updated at acceptance
  task automatic send_sample(logic [11:0] sample, logic cmd);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'd0, sample};
    s_tuser  <= cmd;
    do @(posedge clk); while (!s_tready);
    absorb_sample(sample, cmd);
    samples_sent++;
    if (cmd) cals_sent++;
  endtask

  // drain outstanding readings, let the sequencer settle
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write all four registers back to back
  task automatic write_regs(logic [15:0] b, logic [15:0] w, logic [15:0] r, logic [15:0] f);
    logic [15:0] vals[4];
    vals = '{b, w, r, f};
    wait_drained();
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= 2'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
      case (2'(i))
        REG_BATCH_SIZE:     batch_reg  = vals[i][7:0];
        REG_SMOOTH_WEIGHT:  weight_reg = vals[i];
        REG_REFERENCE_MV:   vref_reg   = vals[i][12:0];
        REG_ADC_FULL_SCALE: fscale_reg = vals[i];
      endcase
    end
    cfg_we <= 1'b0;
  endtask

  task automatic send_batch(int n, logic cmd);
    for (int i = 0; i < n; i++) send_sample(12'($urandom_range(4095)), (i == n - 1) ? cmd : 1'b0);
  endtask

  // reset register values with a couple of full default batches
  task automatic test_reset_config();
    send_batch(100, 1'b0);
    send_batch(100, 1'b1);
  endtask

  // field extremes and corner cases
  task automatic test_directed();
    write_regs(16'd1, 16'd0, 16'd3300, 16'd4096);
    send_sample(12'd0, 1'b0);
    send_sample(12'd4095, 1'b0);
    send_sample(12'd4095, 1'b1);           // calibrate
    send_sample(12'd0, 1'b0);              // far below offset, ppm clips to full scale
    send_sample(12'hAAA, 1'b0);
    send_sample(12'h555, 1'b0);
    // batch size zero behaves as one, full scale zero as one
    write_regs(16'd0, 16'd65535, 16'd5000, 16'd0);
    send_sample(12'd4095, 1'b0);
    send_sample(12'd4095, 1'b1);
    // reference zero gives zero mean
    write_regs(16'd2, 16'd32768, 16'd0, 16'd65535);
    send_batch(2, 1'b0);
    // huge mean clips to 24 bits, then calibrate overflows the offset
    write_regs(16'd1, 16'd0, 16'hFFFF, 16'd1);
    send_sample(12'd4095, 1'b1);
    send_sample(12'd4095, 1'b0);
    // batch size lowered mid-batch closes the batch at the next sample
    write_regs(16'd10, 16'd100, 16'd3300, 16'd4096);
    send_batch(5, 1'b0);
    write_regs(16'd2, 16'd100, 16'd3300, 16'd4096);
    send_sample(12'd2000, 1'b0);
    send_sample(12'd1000, 1'b0);
  endtask

  // random settings and batches under one idling mode
  task automatic test_random(int n_items);
    int sent;
    int b, nb;
    logic [15:0] w, r, f;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(9))
        0:       b = 255;
        1:       b = $urandom_range(255);
        default: b = $urandom_range(1, 8);
      endcase
      case ($urandom_range(5))
        0:       w = 16'd0;
        1:       w = 16'hFFFF;
        default: w = 16'($urandom_range(65535));
      endcase
      case ($urandom_range(5))
        0:       r = 16'd5000;
        1:       r = 16'($urandom);
        default: r = 16'($urandom_range(1, 5000));
      endcase
      case ($urandom_range(5))
        0:       f = 16'd1;
        1:       f = 16'hFFFF;
        2:       f = 16'($urandom_range(65535));
        default: f = 16'($urandom_range(1024, 8192));
      endcase
      write_regs(16'(b), w, r, f);
      if (b == 0) b = 1;
      nb = (b > 50) ? 1 : $urandom_range(2, 12);
      for (int k = 0; k < nb; k++) begin
        send_batch(b, ($urandom_range(9) == 0));
        sent += b;
      end
    end
  endtask

  // receiver, reading checker and watchdog
  always @(posedge clk) begin
    reading_t want;
    if (rst) begin
      m_tready   <= 1'b0;
      idle_count <= 0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_count <= 0;
      else idle_count <= idle_count + 1;
      if (idle_count >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired, %0d readings outstanding", $time,
                 pending_readings.size());
        $display("co2_sensor_ppm_estimator_core regression: fail");
        $finish;
      end
      if (m_tvalid && m_tready) begin
        readings_seen++;
        if (m_tuser[0]) sats_seen++;
        if (pending_readings.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected reading, actual ppm %0d mv %0d sat %0d", $time,
                   m_tdata[19:0], m_tdata[35:20], m_tuser[0]);
        end else begin
          want = pending_readings.pop_front();
          if (m_tdata[19:0] !== want.ppm) begin
            mismatches++;
            $display("%0t: co2_ppm expected %0d actual %0d", $time, want.ppm, m_tdata[19:0]);
          end
          if (m_tdata[35:20] !== want.mv) begin
            mismatches++;
            $display("%0t: voltage_mv expected %0d actual %0d", $time, want.mv,
                     m_tdata[35:20]);
          end
          if (m_tuser[0] !== want.sat) begin
            mismatches++;
            $display("%0t: saturated expected %0d actual %0d", $time, want.sat, m_tuser[0]);
          end
        end
      end
    end
  end

  initial begin
    int waited;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    rst       <= 1'b1;
    mismatches = 0;
    samples_sent = 0;
    readings_seen = 0;
    sats_seen = 0;
    cals_sent = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    batch_reg  = 8'd100;
    weight_reg = 16'd64881;
    vref_reg   = 13'd3300;
    fscale_reg = 16'd4096;
    acc_sum    = '0;
    acc_count  = '0;
    filt_q8    = '0;
    offset_q8  = OFFSET_RESET;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_config();
    test_directed();
    send_idle_pct = 20;
    recv_idle_pct = 67;
    test_random(500);
    send_idle_pct = 67;
    recv_idle_pct = 20;
    test_random(500);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(500);

    // drain and settle
    s_tvalid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    waited = 0;
    while (waited < SETTLE_CYCLES) begin
      @(posedge clk);
      waited++;
    end

    $display("Sent %0d samples (%0d calibrating batch ends), checked %0d readings.",
             samples_sent, cals_sent, readings_seen);
    $display("Saturated readings seen: %0d, mismatches: %0d.", sats_seen, mismatches);
    if (mismatches == 0) begin
      $display("co2_sensor_ppm_estimator_core regression: pass");
    end else begin
      $display("co2_sensor_ppm_estimator_core regression: fail");
    end
    $finish;
  end

endmodule

// File: co2_sensor_ppm_estimator_core.f
+incdir+rtl
rtl/co2ppm_pkg.sv
rtl/co2ppm_div.sv
rtl/co2_sensor_ppm_estimator_core.sv
rtl/co2ppm_checker.sv
bench/tb.sv
